@@ hw/rtl/oled_tg_pkg.sv @@
// ----------------------------------------------------------------------------
// oled_tg_pkg
// Shared types, command codes and the 5x8 font for the OLED text renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package oled_tg_pkg;

  // Geometry
  localparam int DISPLAY_COLUMNS_DEF = 128;
  localparam int GLYPH_WIDTH         = 5;
  localparam int GLYPH_COUNT         = 95;
  localparam int GLYPH_ADDR_W        = $clog2(GLYPH_COUNT);

  // Controller command bytes and character codes
  localparam logic [7:0] CMD_COLUMN_ADDR = 8'h21;
  localparam logic [7:0] CMD_PAGE_ADDR   = 8'h22;
  localparam logic [2:0] LAST_PAGE       = 3'd7;
  localparam logic [7:0] SPACER_BYTE     = 8'h00;
  localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
  localparam logic [7:0] FIRST_GLYPH     = 8'h20;
  localparam logic [7:0] LAST_GLYPH      = 8'h7E;

  // Request kind on in_command
  typedef enum logic {
    REQ_PRINT      = 1'b0,
    REQ_SET_CURSOR = 1'b1
  } req_kind_t;

  // Byte sequencer steps: window commands, then glyph columns, then spacer
  typedef enum logic [3:0] {
    STEP_COL_CMD,
    STEP_COL_START,
    STEP_COL_END,
    STEP_PAGE_CMD,
    STEP_PAGE_START,
    STEP_PAGE_END,
    STEP_GLYPH0,
    STEP_GLYPH1,
    STEP_GLYPH2,
    STEP_GLYPH3,
    STEP_GLYPH4,
    STEP_SPACER
  } step_t;

  // Font: one entry per code 0x20..0x7E, leftmost column in the top byte
  localparam logic [39:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
    40'h0000000000, 40'h00002f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513E,
    40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0003050000, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'hFC24242418,
    40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
    40'h4464544C44, 40'h00107C8200, 40'h0000FF0000,
    40'h00827C1000, 40'h0006090906
  };

endpackage : oled_tg_pkg

`default_nettype wire

@@ hw/rtl/oled_text_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// oled_text_glyph_renderer
// Text-mode character generator: print / set-cursor requests in, command
// and glyph bytes for a page-addressed monochrome OLED controller out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | input     | in_valid / in_ready   | command, char_code, page, column
//  out_    | output    | out_valid / out_ready | is_command, byte_value, last
//
//  One byte leaves per cycle unless out_ready stalls. A request sends 6 bytes
//  (set cursor or newline), 6 or 12 (printable or other character), or none
//  (invalid set cursor). The byte sequencer is the limit; the font ROM read
//  issues at accept and its registered data is ready before the first glyph
//  step. The next request is accepted in the cycle the current last byte
//  moves into the output register. A stalled out_ready holds the sequencer.
//  Reset (rst_n low, synchronous) puts the cursor at page 0, column 0.
//
`default_nettype none

module oled_text_glyph_renderer #(
  parameter int DISPLAY_COLUMNS = oled_tg_pkg::DISPLAY_COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       in_command,
  input  wire logic [7:0] in_char_code,
  input  wire logic [3:0] in_page,
  input  wire logic [7:0] in_column,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_is_command,
  output      logic [7:0] out_byte_value,
  output      logic       out_last
);

  localparam logic [8:0] COLS_9      = 9'(DISPLAY_COLUMNS);
  localparam logic [7:0] LAST_COLUMN = 8'(DISPLAY_COLUMNS - 1);
  localparam logic [8:0] GLYPH_W_9   = 9'(oled_tg_pkg::GLYPH_WIDTH);
  localparam logic [7:0] ADVANCE     = 8'(oled_tg_pkg::GLYPH_WIDTH + 1);

  // Cursor
  logic [2:0] cursor_page_r, cursor_page_nxt;
  logic [7:0] cursor_col_r,  cursor_col_nxt;

  // Active job
  logic                 job_valid_r, job_valid_nxt;
  logic                 job_win_r,   job_win_nxt;
  logic                 job_gly_r,   job_gly_nxt;
  logic [2:0]           win_pg_r,    win_pg_nxt;
  logic [7:0]           win_col_r,   win_col_nxt;
  oled_tg_pkg::step_t   step_r,      step_nxt;

  // Font ROM port
  logic [oled_tg_pkg::GLYPH_ADDR_W-1:0] rom_addr;
  logic [39:0]                          rom_q_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_cmd_r,   out_cmd_nxt;
  logic [7:0] out_byte_r,  out_byte_nxt;
  logic       out_last_r,  out_last_nxt;

  // Request decode
  logic       accept;
  logic       is_set;
  logic       set_ok;
  logic       newline;
  logic       no_fit;
  logic       wrap;
  logic       printable;
  logic [2:0] next_page;
  logic       out_free;
  logic       advance;
  logic       at_last;
  logic [7:0] step_byte;
  logic [2:0] gly_col;

  assign is_set    = (in_command == oled_tg_pkg::REQ_SET_CURSOR);
  assign set_ok    = (in_page[3] == 1'b0) && ({1'b0, in_column} < COLS_9);
  assign newline   = (in_char_code == oled_tg_pkg::NEWLINE_CODE);
  assign no_fit    = ({1'b0, cursor_col_r} + GLYPH_W_9) >= COLS_9;
  assign wrap      = newline || no_fit;
  assign next_page = cursor_page_r + 3'd1;
  assign printable = (in_char_code >= oled_tg_pkg::FIRST_GLYPH) &&
                     (in_char_code <= oled_tg_pkg::LAST_GLYPH);
  assign rom_addr  = printable ?
                     oled_tg_pkg::GLYPH_ADDR_W'(in_char_code - oled_tg_pkg::FIRST_GLYPH) :
                     '0;

  // Sequencer handshake
  assign out_free = !out_valid_r || out_ready;
  assign advance  = job_valid_r && out_free;
  assign at_last  = job_gly_r ? (step_r == oled_tg_pkg::STEP_SPACER)
                              : (step_r == oled_tg_pkg::STEP_PAGE_END);
  assign in_ready = !job_valid_r || (advance && at_last);
  assign accept   = in_valid && in_ready;

  // Next state: cursor and job
  always_comb begin
    cursor_page_nxt = cursor_page_r;
    cursor_col_nxt  = cursor_col_r;
    job_valid_nxt   = job_valid_r;
    job_win_nxt     = job_win_r;
    job_gly_nxt     = job_gly_r;
    win_pg_nxt      = win_pg_r;
    win_col_nxt     = win_col_r;
    step_nxt        = step_r;
    if (advance) begin
      step_nxt = oled_tg_pkg::step_t'(step_r + 4'd1);
      if (at_last) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (is_set) begin
        job_valid_nxt = set_ok;
        job_win_nxt   = 1'b1;
        job_gly_nxt   = 1'b0;
        win_pg_nxt    = in_page[2:0];
        win_col_nxt   = in_column;
        step_nxt      = oled_tg_pkg::STEP_COL_CMD;
        if (set_ok) begin
          cursor_page_nxt = in_page[2:0];
          cursor_col_nxt  = in_column;
        end
      end else begin
        job_valid_nxt = 1'b1;
        job_win_nxt   = wrap;
        job_gly_nxt   = !newline;
        win_pg_nxt    = next_page;
        win_col_nxt   = 8'h00;
        step_nxt      = wrap ? oled_tg_pkg::STEP_COL_CMD : oled_tg_pkg::STEP_GLYPH0;
        if (wrap) begin
          cursor_page_nxt = next_page;
          cursor_col_nxt  = newline ? 8'h00 : ADVANCE;
        end else begin
          cursor_col_nxt  = cursor_col_r + ADVANCE;
        end
      end
    end
  end

  // Byte for the current step
  assign gly_col = 3'(step_r - oled_tg_pkg::STEP_GLYPH0);

  always_comb begin
    unique case (step_r)
      oled_tg_pkg::STEP_COL_CMD:    step_byte = oled_tg_pkg::CMD_COLUMN_ADDR;
      oled_tg_pkg::STEP_COL_START:  step_byte = win_col_r;
      oled_tg_pkg::STEP_COL_END:    step_byte = LAST_COLUMN;
      oled_tg_pkg::STEP_PAGE_CMD:   step_byte = oled_tg_pkg::CMD_PAGE_ADDR;
      oled_tg_pkg::STEP_PAGE_START: step_byte = {5'd0, win_pg_r};
      oled_tg_pkg::STEP_PAGE_END:   step_byte = {5'd0, oled_tg_pkg::LAST_PAGE};
      oled_tg_pkg::STEP_GLYPH0,
      oled_tg_pkg::STEP_GLYPH1,
      oled_tg_pkg::STEP_GLYPH2,
      oled_tg_pkg::STEP_GLYPH3,
      oled_tg_pkg::STEP_GLYPH4:     step_byte = rom_q_r[39 - 8*gly_col -: 8];
      oled_tg_pkg::STEP_SPACER:     step_byte = oled_tg_pkg::SPACER_BYTE;
      default:                      step_byte = oled_tg_pkg::SPACER_BYTE;
    endcase
  end

  // Output register load
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = advance;
      out_cmd_nxt   = (step_r < oled_tg_pkg::STEP_GLYPH0);
      out_byte_nxt  = step_byte;
      out_last_nxt  = at_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_page_r <= '0;
      cursor_col_r  <= '0;
      job_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      step_r        <= oled_tg_pkg::STEP_COL_CMD;
    end else begin
      cursor_page_r <= cursor_page_nxt;
      cursor_col_r  <= cursor_col_nxt;
      job_valid_r   <= job_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      step_r        <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_win_r  <= job_win_nxt;
    job_gly_r  <= job_gly_nxt;
    win_pg_r   <= win_pg_nxt;
    win_col_r  <= win_col_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // Font ROM, synchronous read issued at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      rom_q_r <= oled_tg_pkg::GLYPH_ROM[rom_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_command = out_cmd_r;
  assign out_byte_value = out_byte_r;
  assign out_last       = out_last_r;

  // Checks
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && !at_last) |-> !in_ready)
    else $error("request taken while job mid-sequence");

  a_spacer_only_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && step_r == oled_tg_pkg::STEP_SPACER) |-> job_gly_r)
    else $error("spacer step in a window-only job");

  a_window_steps_need_win: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && step_r < oled_tg_pkg::STEP_GLYPH0) |-> job_win_r)
    else $error("window step in a glyph-only job");

  a_cursor_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(cursor_page_r) && $stable(cursor_col_r)))
    else $error("cursor changed without a request");

endmodule : oled_text_glyph_renderer

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for oled_text_glyph_renderer. Print and set-cursor
// requests go in through a queued driver. A cursor and font model predicts
// the command and glyph bytes that each request should produce, and a monitor
// compares every byte that comes out against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int COLUMNS      = oled_tg_pkg::DISPLAY_COLUMNS_DEF;
  localparam int IDLE_PCT     = 36;
  localparam int RANDOM_REQS  = 107;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  // One request on the input channel
  typedef struct packed {
    oled_tg_pkg::req_kind_t kind;
    logic [7:0]             code;
    logic [3:0]             page;
    logic [7:0]             column;
  } text_req_t;

  // One byte bound for the display
  typedef struct packed {
    logic       is_cmd;
    logic [7:0] value;
    logic       last;
  } disp_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_command = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic [3:0] in_page = 4'h0;
  logic [7:0] in_column = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_command;
  logic [7:0] out_byte_value;
  logic       out_last;

  text_req_t  pending_reqs[$];
  disp_byte_t expected_bytes[$];
  text_req_t  offer;
  logic [2:0] cur_page = 3'd0;
  logic [7:0] cur_column = 8'd0;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         error_count = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  int         cycle_count = 0;
  logic       calm;

  oled_text_glyph_renderer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_page        (in_page),
    .in_column      (in_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_command (out_is_command),
    .out_byte_value (out_byte_value),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // No idling on either side over this window of requests
  assign calm = (n_accepted >= 70) && (n_accepted < 100);

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic queue_req(input oled_tg_pkg::req_kind_t kind, input logic [7:0] code,
                           input logic [3:0] page, input logic [7:0] column);
    text_req_t r;
    r.kind   = kind;
    r.code   = code;
    r.page   = page;
    r.column = column;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic push_byte(input logic is_cmd, input logic [7:0] value);
    disp_byte_t b;
    b.is_cmd = is_cmd;
    b.value  = value;
    b.last   = 1'b0;
    expected_bytes.push_back(b);
  endtask

  // Move the cursor and open the column and page windows from there
  task automatic place_window(input logic [2:0] pg, input logic [7:0] col);
    cur_page   = pg;
    cur_column = col;
    push_byte(1'b1, oled_tg_pkg::CMD_COLUMN_ADDR);
    push_byte(1'b1, col);
    push_byte(1'b1, 8'(COLUMNS - 1));
    push_byte(1'b1, oled_tg_pkg::CMD_PAGE_ADDR);
    push_byte(1'b1, {5'd0, pg});
    push_byte(1'b1, {5'd0, oled_tg_pkg::LAST_PAGE});
  endtask

  // Cursor and font model: bytes that one request sends to the display
  task automatic render_request(input text_req_t r);
    int          first;
    logic [6:0]  idx;
    logic [39:0] glyph;
    disp_byte_t  tail;
    first = expected_bytes.size();
    if (r.kind == oled_tg_pkg::REQ_SET_CURSOR) begin
      // out-of-range positions are dropped silently
      if (r.page <= 4'(oled_tg_pkg::LAST_PAGE) && int'(r.column) < COLUMNS) begin
        place_window(r.page[2:0], r.column);
      end
    end else begin
      if (r.code == oled_tg_pkg::NEWLINE_CODE ||
          int'(cur_column) + oled_tg_pkg::GLYPH_WIDTH >= COLUMNS) begin
        place_window(cur_page + 3'd1, 8'd0);
      end
      if (r.code != oled_tg_pkg::NEWLINE_CODE) begin
        // anything outside the font renders as a blank
        idx = 7'd0;
        if (r.code >= oled_tg_pkg::FIRST_GLYPH && r.code <= oled_tg_pkg::LAST_GLYPH) begin
          idx = 7'(r.code - oled_tg_pkg::FIRST_GLYPH);
        end
        glyph = oled_tg_pkg::GLYPH_ROM[idx];
        for (int k = 0; k < oled_tg_pkg::GLYPH_WIDTH; k++) begin
          push_byte(1'b0, glyph[39 - 8 * k -: 8]);
        end
        push_byte(1'b0, oled_tg_pkg::SPACER_BYTE);
        cur_column = cur_column + 8'(oled_tg_pkg::GLYPH_WIDTH + 1);
      end
    end
    // flag the final byte of this request
    if (expected_bytes.size() > first) begin
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        render_request(offer);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          offer = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          in_command   <= offer.kind;
          in_char_code <= offer.code;
          in_page      <= offer.page;
          in_column    <= offer.column;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while requests keep coming
  always @(posedge clk) begin
    if (!hold_done && n_accepted >= 45) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Byte monitor
  always @(posedge clk) begin
    disp_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte cmd=%0b val=%02h last=%0b",
                                    out_is_command, out_byte_value, out_last));
        end else begin
          want = expected_bytes.pop_front();
          if (out_is_command !== want.is_cmd) begin
            report_mismatch($sformatf("is_command %0b, want %0b",
                                      out_is_command, want.is_cmd));
          end
          if (out_byte_value !== want.value) begin
            report_mismatch($sformatf("byte_value %02h, want %02h",
                                      out_byte_value, want.value));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
          end
        end
      end
      out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    text_req_t r;
    int        made;
    int        sel;
    int        pick;

    // extremes, font edges, newline and the wrap cases
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h41, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, oled_tg_pkg::FIRST_GLYPH, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, oled_tg_pkg::LAST_GLYPH, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h7F, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h00, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, 8'hFF, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h1F, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, oled_tg_pkg::NEWLINE_CODE, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd0, 8'd0);
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd7, 8'd127);
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h21, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd8, 8'd10);
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd15, 8'd0);
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd3, 8'd128);
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd0, 8'd255);
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd5, 8'd122);
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h42, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h43, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'($urandom), 4'd7, 8'd123);
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h78, 4'($urandom), 8'($urandom));
    queue_req(oled_tg_pkg::REQ_SET_CURSOR, 8'hFF, 4'd7, 8'd40);
    queue_req(oled_tg_pkg::REQ_PRINT, oled_tg_pkg::NEWLINE_CODE, 4'hF, 8'hFF);
    queue_req(oled_tg_pkg::REQ_PRINT, 8'h80, 4'hF, 8'hFF);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sender pauses until the directed part has fully drained
    do @(posedge clk); while (n_accepted != n_queued || expected_bytes.size() != 0);

    // random part: mostly text, cursor moves (half near the right edge), some junk
    made = 0;
    while (made < RANDOM_REQS) begin
      r.kind   = oled_tg_pkg::REQ_PRINT;
      r.code   = 8'($urandom);
      r.page   = 4'($urandom);
      r.column = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 62) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          r.code = oled_tg_pkg::NEWLINE_CODE;
        end else if (pick < 80) begin
          r.code = 8'($urandom_range(oled_tg_pkg::FIRST_GLYPH, oled_tg_pkg::LAST_GLYPH));
        end
      end else if (sel < 86) begin
        r.kind = oled_tg_pkg::REQ_SET_CURSOR;
        r.page = 4'($urandom_range(7));
        r.column = $urandom_range(1) ? 8'($urandom_range(110, COLUMNS - 1))
                                     : 8'($urandom_range(COLUMNS - 1));
      end else begin
        r.kind = oled_tg_pkg::REQ_SET_CURSOR;
      end
      queue_req(r.kind, r.code, r.page, r.column);
      made++;
    end

    // wait for the last request and its bytes, then a short tail
    do @(posedge clk); while (n_accepted != n_queued || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire
